// ===== sv/pnm_sample_stream_decoder_assert.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef PNM_SAMPLE_STREAM_DECODER_ASSERT_SVH
`define PNM_SAMPLE_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PNMSSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PNMSSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pnmssd_pkg.sv =====
`timescale 1ns / 1ps

package pnmssd_pkg;

  localparam int ROW_W    = 23;
  localparam int MAXV_W   = 16;
  localparam int ACC_W    = 17;
  localparam int CFG_IDX_W = 3;

  localparam logic [ACC_W-1:0] ACC_MAX = 17'h1ffff;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW       = 3'd3;

  typedef enum logic [1:0] {
    MODE_ASCII  = 2'd0,
    MODE_BITMAP = 2'd1,
    MODE_BYTE   = 2'd2,
    MODE_WORD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PH_SEEK    = 2'd0,
    PH_COMMENT = 2'd1,
    PH_NUMBER  = 2'd2
  } parse_phase_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_DIV  = 2'd1,
    S_PUT  = 2'd2,
    S_BITS = 2'd3
  } ctrl_state_t;

  // Scale request: value already clamped to divisor, divisor nonzero.
  typedef struct packed {
    logic              start;
    logic [MAXV_W-1:0] value;
    logic [MAXV_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== sv/pnmssd_div.sv =====
`timescale 1ns / 1ps

// Computes value*255/divisor, one quotient bit per cycle (8 steps).
// value <= divisor, so the quotient fits in 8 bits.
module pnmssd_div (
  input  logic                clk,
  input  logic                rst,
  input  pnmssd_pkg::div_req_t req,
  output logic                done,
  output logic [7:0]          quotient
);
  import pnmssd_pkg::*;

  logic [23:0] rem;
  logic [23:0] dsh;
  logic [2:0]  cnt;
  logic        running;
  logic        fits;
  logic [23:0] rem_sub;

  assign fits    = (rem >= dsh);
  assign rem_sub = rem - dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && (cnt == 3'd0);
      if (req.start) begin
        running <= 1'b1;
      end else if (running && (cnt == 3'd0)) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // value*255 as value*256 - value
      rem <= {req.value, 8'h00} - {8'h00, req.value};
      dsh <= {1'b0, req.divisor, 7'h00};
      cnt <= 3'd7;
    end else if (running) begin
      if (fits) begin
        rem <= rem_sub;
      end
      quotient <= {quotient[6:0], fits};
      dsh      <= {1'b0, dsh[23:1]};
      cnt      <= cnt - 3'd1;
    end
  end

endmodule

// ===== sv/pnm_sample_stream_decoder.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Word
// -------   ---  -------------------  -----------------------------------
// cfg       in   cfg_write            cfg_index, cfg_data
// in        in   in_valid / in_stall  data_byte, end_of_data
// out       out  out_valid / out_stall sample, row_end, last_of_run
//
// One byte at a time. Byte mode: each byte goes out as its sample. Bitmap:
// the byte is taken, then one sample per cycle (up to 8) while the output
// is not stalled. Scaled samples (ascii numbers, word pairs) run the shared
// divider for 8 steps. Bytes that give no sample leave the decoder idle.
// rst is synchronous; it restores register defaults and clears all parse
// state. A stalled output holds its word; the next input is taken while it
// waits, and a new sample waits in the result register until it is taken.
module pnm_sample_stream_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [pnmssd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pnmssd_pkg::ROW_W-1:0]     cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      data_byte,
  input  logic                            end_of_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      sample,
  output logic                            row_end,
  output logic                            last_of_run
);
  import pnmssd_pkg::*;

  // configuration
  mode_t             mode;
  logic [MAXV_W-1:0] max_value;
  logic              invert_ascii;
  logic [ROW_W-1:0]  row_samples;

  // parse state
  parse_phase_t      phase, phase_next;
  logic [ACC_W-1:0]  accum, accum_next;
  logic              neg, neg_next;
  logic [7:0]        held, held_next;
  logic              bphase, bphase_next;
  logic [ROW_W-1:0]  row_pos;

  // control
  ctrl_state_t       state, state_next;
  logic              in_acc;
  logic              out_free;
  logic              load_out;
  logic              want_div, want_put, want_bits;
  logic              inv_next;
  logic [MAXV_W-1:0] div_val;
  logic [MAXV_W-1:0] divisor;
  div_req_t          req;
  logic              div_done;
  logic [7:0]        quotient;

  // result staging
  logic [7:0]        res_sample;
  logic              res_inv;
  logic [7:0]        bits;
  logic [2:0]        bit_cnt;
  logic              bit_last;
  logic [ROW_W-1:0]  pos_inc;
  logic              at_row_end;
  logic [7:0]        load_sample;
  logic              load_last;

  // ascii helpers
  logic              is_digit;
  logic [3:0]        digit;
  logic [20:0]       acc_mul;
  logic [ACC_W-1:0]  num_val;
  logic [MAXV_W-1:0] num_clamp;
  logic [MAXV_W-1:0] word_val;
  logic [MAXV_W-1:0] word_clamp;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign divisor  = (max_value == '0) ? {{(MAXV_W-1){1'b0}}, 1'b1} : max_value;

  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign digit    = 4'(data_byte - CH_ZERO);
  assign acc_mul  = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0} + {17'h0, digit};

  assign num_val   = neg ? '0 : accum;
  assign num_clamp = (num_val > {1'b0, divisor}) ? divisor : num_val[MAXV_W-1:0];
  assign word_val  = {held, data_byte};
  assign word_clamp = (word_val > divisor) ? divisor : word_val;

  // row tracking: position after this sample, wrapped to the counter width
  assign pos_inc    = row_pos + 1'b1;
  assign at_row_end = (pos_inc >= row_samples);
  assign bit_last   = (bit_cnt == 3'd7) || at_row_end;

  // decode of one accepted word
  always_comb begin
    phase_next  = phase;
    accum_next  = accum;
    neg_next    = neg;
    held_next   = held;
    bphase_next = bphase;
    want_div    = 1'b0;
    want_put    = 1'b0;
    want_bits   = 1'b0;
    inv_next    = 1'b0;
    div_val     = word_clamp;
    if (end_of_data) begin
      if ((mode == MODE_ASCII) && (phase == PH_NUMBER)) begin
        want_div = 1'b1;
        div_val  = num_clamp;
        inv_next = invert_ascii;
      end
      phase_next  = PH_SEEK;
      accum_next  = '0;
      neg_next    = 1'b0;
      bphase_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_ASCII: begin
          unique case (phase)
            PH_COMMENT: begin
              if (data_byte == CH_LF) phase_next = PH_SEEK;
            end
            PH_NUMBER: begin
              if (is_digit) begin
                accum_next = (acc_mul > {4'h0, ACC_MAX}) ? ACC_MAX : acc_mul[ACC_W-1:0];
              end else begin
                // terminator is swallowed
                want_div   = 1'b1;
                div_val    = num_clamp;
                inv_next   = invert_ascii;
                phase_next = PH_SEEK;
                accum_next = '0;
                neg_next   = 1'b0;
              end
            end
            default: begin
              if (is_digit) begin
                phase_next = PH_NUMBER;
                accum_next = {13'h0, digit};
                neg_next   = 1'b0;
              end else if (data_byte == CH_MINUS) begin
                phase_next = PH_NUMBER;
                accum_next = '0;
                neg_next   = 1'b1;
              end else if (data_byte == CH_HASH) begin
                phase_next = PH_COMMENT;
              end else begin
                phase_next = PH_SEEK;
              end
            end
          endcase
        end
        MODE_BITMAP: want_bits = 1'b1;
        MODE_BYTE:   want_put  = 1'b1;
        MODE_WORD: begin
          if (!bphase) begin
            held_next   = data_byte;
            bphase_next = 1'b1;
          end else begin
            want_div    = 1'b1;
            bphase_next = 1'b0;
          end
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          priority if (want_div)  state_next = S_DIV;
          else if (want_put)      state_next = S_PUT;
          else if (want_bits)     state_next = S_BITS;
          else                    state_next = S_IDLE;
        end
      end
      S_DIV:  if (div_done) state_next = S_PUT;
      S_PUT:  if (out_free) state_next = S_IDLE;
      S_BITS: if (out_free && bit_last) state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall    = (state != S_IDLE);
    req.start   = in_acc && want_div;
    req.value   = div_val;
    req.divisor = divisor;
    load_out    = 1'b0;
    load_sample = res_sample;
    load_last   = 1'b1;
    unique case (state)
      S_PUT: load_out = out_free;
      S_BITS: begin
        load_out    = out_free;
        load_sample = bits[7] ? 8'h00 : 8'hff;
        load_last   = bit_last;
      end
      default: load_out = 1'b0;
    endcase
  end

  pnmssd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= MODE_ASCII;
      max_value    <= 16'd255;
      invert_ascii <= 1'b0;
      row_samples  <= {{(ROW_W-1){1'b0}}, 1'b1};
      phase        <= PH_SEEK;
      accum        <= '0;
      neg          <= 1'b0;
      held         <= '0;
      bphase       <= 1'b0;
      row_pos      <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_MODE:      mode         <= mode_t'(cfg_data[1:0]);
          CFG_MAX_VALUE: max_value    <= cfg_data[MAXV_W-1:0];
          CFG_INVERT:    invert_ascii <= cfg_data[0];
          CFG_ROW:       row_samples  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase  <= phase_next;
        accum  <= accum_next;
        neg    <= neg_next;
        held   <= held_next;
        bphase <= bphase_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        row_pos   <= at_row_end ? '0 : pos_inc;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_sample <= data_byte;
      res_inv    <= inv_next;
      bits       <= data_byte;
      bit_cnt    <= 3'd0;
    end else if (div_done) begin
      res_sample <= quotient ^ {8{res_inv}};
    end else if (load_out && (state == S_BITS)) begin
      bits    <= {bits[6:0], 1'b0};
      bit_cnt <= bit_cnt + 3'd1;
    end
    if (load_out) begin
      sample      <= load_sample;
      row_end     <= at_row_end;
      last_of_run <= load_last;
    end
  end

`include "pnm_sample_stream_decoder_assert.svh"

  `PNMSSD_ASSERT_NOW(a_done_in_div, div_done, state == S_DIV, "divider done outside scale")
  `PNMSSD_ASSERT_NEXT(a_div_holds, (state == S_DIV) && !div_done, state == S_DIV, "left scale early")
  `PNMSSD_ASSERT_NEXT(a_put_loads, (state == S_PUT) && out_free, out_valid && (state == S_IDLE), "result not loaded")
  `PNMSSD_ASSERT_NOW(a_partial_run, out_valid && !last_of_run, state == S_BITS, "open run outside bitmap")

endmodule
